// ===== rtl/urzc_pkg.sv =====
// Shared types and constants for the ultrasonic range zone classifier.
// Used by the controller, datapath and top level.
package urzc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned ZONE_W     = 3;

  // Low settle time ahead of every trigger, in ticks.
  localparam logic [31:0] SETTLE_TICKS = 32'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_HIGH = 3'd7;

  // Zone codes.
  localparam logic [ZONE_W-1:0] ZONE_NONE    = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_FAR     = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_NEAR    = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_CONTACT = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_BETWEEN = 3'd4;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_INC   = 2'd1,
    CNT_CLEAR = 2'd2,
    CNT_ONE   = 2'd3
  } cnt_op_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    latch_echo;
    cnt_op_t cnt_op;
    logic    accumulate;
    logic    sample_adv;
    logic    round_clear;
    logic    div_start;
    logic    res_load;
    logic    res_trig;
    logic    res_done;
    logic    res_failed;
    logic    emit;
  } urzc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic echo;
    logic settle_hit;
    logic trig_hit;
    logic wait_hit;
    logic meas_hit;
    logic gap_hit;
    logic last_sample;
    logic any_valid;
    logic div_busy;
    logic out_free;
  } urzc_stat_t;

endpackage

// ===== rtl/urzc_in_if.sv =====
// Input channel: one tick carrying the sampled echo level.
// Valid/ready handshake; no dependencies.
interface urzc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

// ===== rtl/urzc_out_if.sv =====
// Result channel: trigger drive and round summary for one tick.
// Valid/ready handshake; no dependencies.
interface urzc_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic        round_done;
  logic        sensor_failed;
  logic [15:0] average_ticks;
  logic [2:0]  zone;

  modport source (output valid, output trigger_level, output round_done,
                  output sensor_failed, output average_ticks, output zone,
                  input ready);
  modport sink   (input valid, input trigger_level, input round_done,
                  input sensor_failed, input average_ticks, input zone,
                  output ready);
endinterface

// ===== rtl/ultrasonic_range_zone_classifier.sv =====
// Ultrasonic range zone classifier, top level.
// Depends on urzc_pkg, urzc_in_if, urzc_out_if, urzc_ctrl and urzc_dpath.
//
// Usage:
//   in_ch carries one tick per transfer with the sampled echo level; out_ch
//   returns exactly one result per tick: the trigger drive for that tick and,
//   on the tick that ends a measurement round, the round summary (failure
//   flag, averaged echo width and distance zone). Off round ends the summary
//   fields read zero. cfg_we/cfg_index/cfg_data write the eight setup
//   registers (trigger length, timeout, gap, band thresholds); write them only
//   while no tick is in flight.
// Timing:
//   A tick passes from transfer to a loaded result through the accept, phase
//   step and output load steps; the output load waits while the output
//   register is full. A tick that closes a round with at least one valid
//   sample also runs the restoring divider, one quotient bit per cycle,
//   before the output load. One tick is in flight at a time.
// Reset (synchronous, rst_n low): phase machine to settle, counters, sum and
//   last average to zero, registers to their defaults, output empty.
// Stall: the output register holds a finished result while out_ch.ready is
//   low; the next tick is still accepted and processed, and waits in the
//   output load step until the register frees up.
module ultrasonic_range_zone_classifier
  import urzc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_ROUND = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  urzc_in_if.sink               in_ch,
  urzc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  urzc_cmd_t  cmd;
  urzc_stat_t stat;
  logic       in_ready;

  // Sequencing and phase decisions.
  urzc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Counters, accumulation, divide, classify and the output register.
  urzc_dpath #(
    .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .echo_level        (in_ch.echo_level),
    .out_ready         (out_ch.ready),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_ch.valid),
    .out_trigger_level (out_ch.trigger_level),
    .out_round_done    (out_ch.round_done),
    .out_sensor_failed (out_ch.sensor_failed),
    .out_average_ticks (out_ch.average_ticks),
    .out_zone          (out_ch.zone)
  );

  assign in_ch.ready = in_ready;

  // A tick in flight blocks the next transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a tick is in flight");

  // No new tick while the divider runs.
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> !in_ch.ready)
    else $error("input ready during average divide");

  // Summary fields stay zero off a round end.
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.round_done) |->
      (!out_ch.sensor_failed && out_ch.average_ticks == '0 && out_ch.zone == ZONE_NONE))
    else $error("summary fields set off a round end");

  // A round end never coincides with the trigger pulse.
  a_done_no_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.round_done) |-> !out_ch.trigger_level)
    else $error("round end reported during trigger pulse");

endmodule

// ===== rtl/urzc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the round average.
// Standalone; used by urzc_dpath.
module urzc_div #(
  parameter int unsigned DW = 19,
  parameter int unsigned VW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] den_r, den_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/urzc_dpath.sv =====
// Datapath: configuration registers, phase counter, width accumulator,
// averaging divider, classifier and output register. Uses urzc_pkg, urzc_div.
module urzc_dpath
  import urzc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_ROUND = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  echo_level,
  input  logic                  out_ready,
  input  urzc_cmd_t             cmd,
  output urzc_stat_t            stat,
  output logic                  out_valid,
  output logic                  out_trigger_level,
  output logic                  out_round_done,
  output logic                  out_sensor_failed,
  output logic [AVG_W-1:0]      out_average_ticks,
  output logic [ZONE_W-1:0]     out_zone
);

  localparam int unsigned IDX_W = $clog2(SAMPLES_PER_ROUND + 1);
  localparam int unsigned SUM_W = AVG_W + IDX_W;

  // Configuration
  logic [15:0] trig_r;
  logic [31:0] timeout_r, gap_r;
  logic [15:0] no_target_r, far_low_r, far_high_r, near_low_r, near_high_r;

  logic [31:0]      cnt_r, cnt_nxt, cnt_inc;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] vc_r, vc_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [AVG_W-1:0] last_avg_r, last_avg_nxt;
  logic             echo_r;
  logic             res_trig_r, res_done_r, res_failed_r;
  logic [AVG_W-1:0] width_sat;

  logic              out_valid_r, out_valid_nxt;
  logic              out_trig_r, out_done_r, out_failed_r;
  logic [AVG_W-1:0]  out_avg_r;
  logic [ZONE_W-1:0] out_zone_r, zone_class;

  logic             div_busy, div_done;
  logic [SUM_W-1:0] div_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r      <= 16'd10;
      timeout_r   <= 32'd100000;
      gap_r       <= 32'd100000;
      no_target_r <= 16'd4060;
      far_low_r   <= 16'd1740;
      far_high_r  <= 16'd3480;
      near_low_r  <= 16'd580;
      near_high_r <= 16'd1160;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER:   trig_r      <= cfg_data[15:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data;
        CFG_GAP:       gap_r       <= cfg_data;
        CFG_NO_TARGET: no_target_r <= cfg_data[15:0];
        CFG_FAR_LOW:   far_low_r   <= cfg_data[15:0];
        CFG_FAR_HIGH:  far_high_r  <= cfg_data[15:0];
        CFG_NEAR_LOW:  near_low_r  <= cfg_data[15:0];
        CFG_NEAR_HIGH: near_high_r <= cfg_data[15:0];
      endcase
    end
  end

  assign cnt_inc   = cnt_r + 32'd1;
  assign width_sat = (|cnt_r[31:AVG_W]) ? {AVG_W{1'b1}} : cnt_r[AVG_W-1:0];

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD:  cnt_nxt = cnt_r;
      CNT_INC:   cnt_nxt = cnt_inc;
      CNT_CLEAR: cnt_nxt = '0;
      CNT_ONE:   cnt_nxt = 32'd1;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    vc_nxt  = vc_r;
    sum_nxt = sum_r;
    if (cmd.round_clear) begin
      idx_nxt = '0;
      vc_nxt  = '0;
      sum_nxt = '0;
    end else begin
      if (cmd.sample_adv) idx_nxt = idx_r + IDX_W'(1);
      if (cmd.accumulate) begin
        vc_nxt  = vc_r + IDX_W'(1);
        sum_nxt = sum_r + SUM_W'(width_sat);
      end
    end
  end

  assign last_avg_nxt = div_done ? div_quo[AVG_W-1:0] : last_avg_r;

  urzc_div #(
    .DW (SUM_W),
    .VW (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (vc_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Band classification in priority order.
  always_comb begin
    if (last_avg_r > no_target_r) begin
      zone_class = ZONE_NONE;
    end else if (last_avg_r >= far_low_r && last_avg_r <= far_high_r) begin
      zone_class = ZONE_FAR;
    end else if (last_avg_r >= near_low_r && last_avg_r <= near_high_r) begin
      zone_class = ZONE_NEAR;
    end else if (last_avg_r <= near_low_r) begin
      zone_class = ZONE_CONTACT;
    end else begin
      zone_class = ZONE_BETWEEN;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      vc_r        <= '0;
      sum_r       <= '0;
      last_avg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      vc_r        <= vc_nxt;
      sum_r       <= sum_nxt;
      last_avg_r  <= last_avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.latch_echo) echo_r <= echo_level;
    if (cmd.res_load) begin
      res_trig_r   <= cmd.res_trig;
      res_done_r   <= cmd.res_done;
      res_failed_r <= cmd.res_failed;
    end
    if (cmd.emit) begin
      out_trig_r   <= res_trig_r;
      out_done_r   <= res_done_r;
      out_failed_r <= res_failed_r;
      out_avg_r    <= res_done_r ? last_avg_r : '0;
      out_zone_r   <= res_done_r ? zone_class : ZONE_NONE;
    end
  end

  assign stat.echo        = echo_r;
  assign stat.settle_hit  = cnt_inc >= SETTLE_TICKS;
  assign stat.trig_hit    = cnt_inc >= {16'd0, trig_r};
  assign stat.wait_hit    = cnt_inc >= timeout_r;
  assign stat.meas_hit    = cnt_r >= timeout_r;
  assign stat.gap_hit     = cnt_inc >= gap_r;
  assign stat.last_sample = (32'(idx_r) + 32'd1) >= 32'(SAMPLES_PER_ROUND);
  assign stat.any_valid   = vc_r != '0;
  assign stat.div_busy    = div_busy;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_trigger_level = out_trig_r;
  assign out_round_done    = out_done_r;
  assign out_sensor_failed = out_failed_r;
  assign out_average_ticks = out_avg_r;
  assign out_zone          = out_zone_r;

endmodule

// ===== rtl/urzc_ctrl.sv =====
// Controller: tick handshake sequencer and ranging phase machine.
// Uses urzc_pkg; drives urzc_dpath through command and status structs.
module urzc_ctrl
  import urzc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  urzc_stat_t stat,
  output urzc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } seq_state_t;

  typedef enum logic [4:0] {
    PH_SETTLE  = 5'b00001,
    PH_TRIGGER = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_MEASURE = 5'b01000,
    PH_GAP     = 5'b10000
  } phase_t;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_echo = in_valid;
        if (in_valid) state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.res_load = 1'b1;
        cmd.res_trig = (phase_r == PH_TRIGGER);
        cmd.cnt_op   = CNT_INC;
        unique case (phase_r)
          PH_SETTLE: begin
            if (stat.settle_hit) begin
              phase_nxt  = PH_TRIGGER;
              cmd.cnt_op = CNT_CLEAR;
            end
          end
          PH_TRIGGER: begin
            if (stat.trig_hit) begin
              phase_nxt  = PH_WAIT;
              cmd.cnt_op = CNT_CLEAR;
            end
          end
          PH_WAIT: begin
            if (stat.echo) begin
              phase_nxt  = PH_MEASURE;
              cmd.cnt_op = CNT_ONE;
            end else if (stat.wait_hit) begin
              phase_nxt  = PH_GAP;
              cmd.cnt_op = CNT_CLEAR;
            end
          end
          PH_MEASURE: begin
            if (!stat.echo) begin
              cmd.accumulate = 1'b1;
              phase_nxt      = PH_GAP;
              cmd.cnt_op     = CNT_CLEAR;
            end else if (stat.meas_hit) begin
              phase_nxt  = PH_GAP;
              cmd.cnt_op = CNT_CLEAR;
            end
          end
          PH_GAP: begin
            if (stat.gap_hit) begin
              phase_nxt  = PH_SETTLE;
              cmd.cnt_op = CNT_CLEAR;
              if (stat.last_sample) begin
                cmd.res_done    = 1'b1;
                cmd.res_failed  = !stat.any_valid;
                cmd.div_start   = stat.any_valid;
                cmd.round_clear = 1'b1;
              end else begin
                cmd.sample_adv = 1'b1;
              end
            end
          end
        endcase
        state_nxt = cmd.div_start ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (!stat.div_busy) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_SETTLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
